>>> rtl/hsort_pkg.sv
`timescale 1ns / 1ps
// Shared sizes, payload structs and controller/datapath command types for heap_sorter.
// No dependencies.
package hsort_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int OUT_W      = 32;
    // store address, element count and child index widths
    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CIW = AW + 2;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_run;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic load;
        logic start;
        logic bld_rd;
        logic bld_ld;
        logic sift_rd;
        logic sift_cmp;
        logic idx_dec;
        logic ext_init;
        logic ext_rd;
        logic ext_wr;
        logic out_init;
        logic out_rd;
        logic out_ld;
        logic idx_inc;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic cnt_one;
        logic idx_one;
        logic sift_done;
        logic out_last;
    } t_sts;

endpackage

>>> rtl/hsort_dp.sv
`timescale 1ns / 1ps
// Datapath for heap_sorter: element store (one write, two registered reads),
// sift-down compare, indices, element count and result register. Uses hsort_pkg.
module hsort_dp import hsort_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in_data,
    output t_sts o_sts,
    output t_out o_out_data
);

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rda, r_rdb;
    logic [DATA_WIDTH-1:0] r_cur, n_cur;
    logic [AW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_size, n_size;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_drop, n_drop;
    t_out                  r_out, n_out;

    logic                  we;
    logic [AW-1:0]         wa, ra_a, ra_b;
    logic [DATA_WIDTH-1:0] wd, in_val, big_val;
    logic [CIW-1:0]        lc, rc;
    logic                  l_ok, r_ok, pick_l, pick_r;
    logic [AW-1:0]         child;
    logic [AW-1:0]         cnt_m1;

    always_comb begin
        in_val = DATA_WIDTH'($unsigned(i_in_data.value));
        lc     = {1'b0, r_pos, 1'b1};
        rc     = lc + CIW'(1);
        l_ok   = lc < CIW'(r_size);
        r_ok   = rc < CIW'(r_size);
        // the sifted value sits in r_cur; children come from the read ports
        pick_l  = l_ok && ($signed(r_rda) > $signed(r_cur));
        big_val = pick_l ? r_rda : r_cur;
        pick_r  = r_ok && ($signed(r_rdb) > $signed(big_val));
        if (pick_r) begin
            big_val = r_rdb;
        end
        child  = pick_r ? rc[AW-1:0] : lc[AW-1:0];
        cnt_m1 = AW'(r_cnt - CW'(1));
    end

    always_comb begin
        we     = 1'b0;
        wa     = r_pos;
        wd     = big_val;
        ra_a   = r_idx;
        ra_b   = r_idx;
        n_cur  = r_cur;
        n_pos  = r_pos;
        n_idx  = r_idx;
        n_size = r_size;
        n_cnt  = r_cnt;
        n_drop = r_drop;
        n_out  = r_out;

        if (i_cmd.load) begin
            if (r_cnt < CW'(CAPACITY)) begin
                we    = 1'b1;
                wa    = r_cnt[AW-1:0];
                wd    = in_val;
                n_cnt = r_cnt + CW'(1);
            end else begin
                n_drop = 1'b1;
            end
        end
        if (i_cmd.start) begin
            n_size = r_cnt;
            n_idx  = AW'(r_cnt >> 1);
        end
        if (i_cmd.bld_rd) begin
            ra_a = r_idx - AW'(1);
        end
        if (i_cmd.bld_ld) begin
            n_cur = r_rda;
            n_pos = r_idx - AW'(1);
        end
        if (i_cmd.sift_rd) begin
            ra_a = lc[AW-1:0];
            ra_b = rc[AW-1:0];
        end
        if (i_cmd.sift_cmp) begin
            // drop the larger of the three into the hole and follow it down
            we = 1'b1;
            wa = r_pos;
            wd = big_val;
            if (pick_l || pick_r) begin
                n_pos = child;
            end
        end
        if (i_cmd.idx_dec) begin
            n_idx = r_idx - AW'(1);
        end
        if (i_cmd.ext_init) begin
            n_idx = cnt_m1;
        end
        if (i_cmd.ext_rd) begin
            ra_a = '0;
            ra_b = r_idx;
        end
        if (i_cmd.ext_wr) begin
            // move the root to the tail and sift the old tail from the root
            we     = 1'b1;
            wa     = r_idx;
            wd     = r_rda;
            n_cur  = r_rdb;
            n_pos  = '0;
            n_size = CW'(r_idx);
        end
        if (i_cmd.out_init) begin
            n_idx = '0;
        end
        if (i_cmd.out_rd) begin
            ra_a = r_idx;
        end
        if (i_cmd.out_ld) begin
            n_out.sorted_value = OUT_W'(r_rda);
            n_out.end_of_run   = (r_idx == cnt_m1);
            n_out.overflow     = r_drop;
        end
        if (i_cmd.idx_inc) begin
            n_idx = r_idx + AW'(1);
        end
        if (i_cmd.clear) begin
            n_cnt  = '0;
            n_drop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rda <= r_mem[ra_a];
        r_rdb <= r_mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_size <= n_size;
        r_out  <= n_out;
    end

    assign o_sts.cnt_one   = (r_cnt == CW'(1));
    assign o_sts.idx_one   = (r_idx == AW'(1));
    assign o_sts.sift_done = !(pick_l || pick_r);
    assign o_sts.out_last  = (r_idx == cnt_m1);
    assign o_out_data      = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_sift_descends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sift_cmp && !o_sts.sift_done) |=> (r_pos > $past(r_pos)))
        else $error("sift step did not move down the heap");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !i_cmd.clear && r_cnt == CW'(CAPACITY)) |=> r_drop)
        else $error("element into full store not flagged");

endmodule

>>> rtl/hsort_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for heap_sorter: load, heap build, extraction and
// result phases. Drives hsort_dp commands. Uses hsort_pkg.
module hsort_ctrl import hsort_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_LOAD      = 14'b00000000000001,
        S_START     = 14'b00000000000010,
        S_BLD_RD    = 14'b00000000000100,
        S_BLD_LD    = 14'b00000000001000,
        S_BSIFT_RD  = 14'b00000000010000,
        S_BSIFT_CMP = 14'b00000000100000,
        S_EXT_INIT  = 14'b00000001000000,
        S_EXT_RD    = 14'b00000010000000,
        S_EXT_WR    = 14'b00000100000000,
        S_ESIFT_RD  = 14'b00001000000000,
        S_ESIFT_CMP = 14'b00010000000000,
        S_OUT_RD    = 14'b00100000000000,
        S_OUT_LD    = 14'b01000000000000,
        S_OUT_WAIT  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                // a single element needs no sort; index lands on zero
                o_cmd.start = 1'b1;
                n_state = i_sts.cnt_one ? S_OUT_RD : S_BLD_RD;
            end
            S_BLD_RD: begin
                o_cmd.bld_rd = 1'b1;
                n_state = S_BLD_LD;
            end
            S_BLD_LD: begin
                o_cmd.bld_ld = 1'b1;
                n_state = S_BSIFT_RD;
            end
            S_BSIFT_RD: begin
                o_cmd.sift_rd = 1'b1;
                n_state = S_BSIFT_CMP;
            end
            S_BSIFT_CMP: begin
                o_cmd.sift_cmp = 1'b1;
                if (!i_sts.sift_done) begin
                    n_state = S_BSIFT_RD;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                    n_state = i_sts.idx_one ? S_EXT_INIT : S_BLD_RD;
                end
            end
            S_EXT_INIT: begin
                o_cmd.ext_init = 1'b1;
                n_state = S_EXT_RD;
            end
            S_EXT_RD: begin
                o_cmd.ext_rd = 1'b1;
                n_state = S_EXT_WR;
            end
            S_EXT_WR: begin
                o_cmd.ext_wr = 1'b1;
                n_state = S_ESIFT_RD;
            end
            S_ESIFT_RD: begin
                o_cmd.sift_rd = 1'b1;
                n_state = S_ESIFT_CMP;
            end
            S_ESIFT_CMP: begin
                o_cmd.sift_cmp = 1'b1;
                if (!i_sts.sift_done) begin
                    n_state = S_ESIFT_RD;
                end else if (i_sts.idx_one) begin
                    o_cmd.out_init = 1'b1;
                    n_state = S_OUT_RD;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                    n_state = S_EXT_RD;
                end
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                // hold the result until the transaction completes
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT_WAIT);

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output phases overlap");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_sts.out_last) |=> (r_state == S_LOAD))
        else $error("final result did not return to load");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && i_sts.cnt_one) |=> (r_state == S_OUT_RD))
        else $error("single element set did not skip the sort");

endmodule

>>> rtl/heap_sorter.sv
`timescale 1ns / 1ps
// After the last element of a set, the heap build and the extraction phases each run
// the sift-down compare loop (read two children, compare, write one entry) on the
// two-read, one-write element store.
// Elements load one per cycle in load; the next result is fetched once the last is taken.
// Reset clears the element count, the overflow flag and the controller; the store keeps data.
// Top level for heap_sorter: joins hsort_ctrl and hsort_dp. Uses hsort_pkg.
module heap_sorter import hsort_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    hsort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    hsort_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

>>> test/heap_sorter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for heap_sorter: queued element sets drive the input channel,
// a monitor checks every sorted element against an in-bench sorter. Uses hsort_pkg.
module heap_sorter_tb import hsort_pkg::*; ();

    typedef struct packed {
        t_in        item;
        logic [2:0] gap;
        logic       drain;
        logic       calm;
    } t_pending;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data  = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    // in-bench copy of the element buffer
    logic signed [31:0] held_vals [CAPACITY];
    logic [6:0]         held_cnt  = '0;
    logic               held_drop = 1'b0;

    t_out     sorted_due [$];
    t_pending pending_q  [$];
    t_pending cur;
    bit       holding    = 1'b0;
    bit       phase_calm = 1'b0;
    bit       rx_calm    = 1'b0;
    int       tx_wait    = 0;
    int       rx_wait    = 0;
    int       errors     = 0;

    heap_sorter DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #1 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        errors++;
    endtask

    // Store or drop one element; on the closing element sort the set and queue its results.
    task automatic take_element(input t_in it);
        logic signed [31:0] key;
        t_out               res;
        int                 i;
        int                 j;
        if (held_cnt < CAPACITY) begin
            held_vals[held_cnt] = it.value;
            held_cnt++;
        end else begin
            held_drop = 1'b1;
        end
        if (it.last) begin
            for (i = 1; i < held_cnt; i++) begin
                key = held_vals[i];
                j = i - 1;
                while (j >= 0 && held_vals[j] > key) begin
                    held_vals[j + 1] = held_vals[j];
                    j--;
                end
                held_vals[j + 1] = key;
            end
            for (i = 0; i < held_cnt; i++) begin
                res.sorted_value = held_vals[i];
                res.end_of_run   = (i == held_cnt - 1);
                res.overflow     = held_drop;
                sorted_due.push_back(res);
            end
            held_cnt  = '0;
            held_drop = 1'b0;
        end
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (sorted_due.size() == 0) begin
            flag_error($sformatf("unexpected result, value %0d", got.sorted_value));
            return;
        end
        want = sorted_due.pop_front();
        if (got.sorted_value !== want.sorted_value)
            flag_error($sformatf("sorted_value got %0d want %0d",
                                 got.sorted_value, want.sorted_value));
        if (got.end_of_run !== want.end_of_run)
            flag_error($sformatf("end_of_run got %b want %b", got.end_of_run, want.end_of_run));
        if (got.overflow !== want.overflow)
            flag_error($sformatf("overflow got %b want %b", got.overflow, want.overflow));
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_elem(input logic signed [31:0] v, input logic last, input bit drain);
        t_pending p;
        p.item.value = v;
        p.item.last  = last;
        p.gap        = phase_calm ? 3'd0 : 3'($urandom_range(0, 6));
        p.drain      = drain;
        p.calm       = phase_calm;
        pending_q.push_back(p);
    endtask

    task automatic add_set(input int n, input bit drain);
        int k;
        for (k = 0; k < n; k++)
            add_elem(pick_value(), k == n - 1, drain && k == 0);
    endtask

    // Driver: wait each transaction's gap before showing it, then hold it until accepted.
    always @(posedge clk) begin
        bit show;
        if (!rst_n) begin
            in_valid <= 1'b0;
            holding = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                take_element(in_data);
                holding = 1'b0;
            end
            if (!holding && pending_q.size() > 0) begin
                cur = pending_q.pop_front();
                tx_wait = cur.gap;
                rx_calm = cur.calm;
                holding = 1'b1;
            end
            show = holding && tx_wait == 0 && (!cur.drain || sorted_due.size() == 0);
            if (holding && tx_wait > 0)
                tx_wait--;
            in_valid <= show;
            if (show)
                in_data <= cur.item;
        end
    end

    // Monitor: check each accepted result, then may hold ready low for a random wait, never in calm phases.
    always @(posedge clk) begin
        bit rdy;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            rdy = out_ready;
            if (out_valid && out_ready) begin
                check_result(out_data);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
                rdy = (rx_wait == 0);
            end else if (!out_ready) begin
                if (rx_wait > 0)
                    rx_wait--;
                rdy = (rx_wait == 0);
            end
            out_ready <= rdy;
        end
    end

    initial begin
        int s;
        int n;
        int queued;
        // single element, largest value
        add_elem(32'sh7fff_ffff, 1'b1, 1'b0);
        // both extremes, zero and the values around it
        add_elem(32'sh8000_0000, 1'b0, 1'b0);
        add_elem(32'sh7fff_ffff, 1'b0, 1'b0);
        add_elem(32'sh0000_0000, 1'b0, 1'b0);
        add_elem(-32'sd1, 1'b0, 1'b0);
        add_elem(32'sd1, 1'b1, 1'b0);
        // equal values; hold off until the previous set has drained
        add_elem(32'sd7, 1'b0, 1'b1);
        add_elem(32'sd7, 1'b0, 1'b0);
        add_elem(32'sd7, 1'b1, 1'b0);
        // reverse order, back to back
        phase_calm = 1'b1;
        add_elem(32'sd4, 1'b0, 1'b0);
        add_elem(32'sd3, 1'b0, 1'b0);
        add_elem(32'sd2, 1'b0, 1'b0);
        add_elem(32'sd1, 1'b1, 1'b0);
        phase_calm = 1'b0;
        add_elem(32'sh8000_0000, 1'b0, 1'b0);
        add_elem(32'sh8000_0000, 1'b1, 1'b0);
        add_elem(32'sh5555_5555, 1'b0, 1'b0);
        add_elem(32'shaaaa_aaaa, 1'b1, 1'b0);

        // random sets, mostly small; the fixed sets above hold 17 elements
        queued = 17;
        s = 0;
        while (queued < 120) begin
            phase_calm = (s % 5 == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            add_set(n, $urandom_range(0, 7) == 0);
            queued += n;
            s++;
            if (s == 2) begin
                // fill the buffer, then two drops, the closing element among them
                phase_calm = 1'b0;
                add_set(CAPACITY + 2, 1'b1);
                queued += CAPACITY + 2;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() > 0 || holding)
            @(posedge clk);
        while (sorted_due.size() > 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("heap_sorter regression: pass");
        else
            $display("heap_sorter regression: fail");
        $finish;
    end

    initial begin
        #400000;
        $display("heap_sorter regression: fail");
        $finish;
    end

endmodule
